[rtl/uts_pkg.sv]
// shared types and constants for the unaligned transfer splitter
`timescale 1ns / 1ps

package uts_pkg;

  localparam int unsigned MAX_RESULTS = 40;
  localparam int unsigned N_W         = $clog2(MAX_RESULTS);
  localparam int unsigned BULK_CAP    = 256;

  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [3:0]  MASK_RESET  = 4'hf;
  localparam logic [15:0] BE_FULL     = 16'hffff;
  localparam logic [6:0]  SMALL_WORDS = 7'd4;

  typedef struct packed {
    logic [8:0]  bytes;
    logic [6:0]  words;
    logic [15:0] be;
    logic        bulk;
  } chunk_t;

  typedef struct packed {
    logic [31:0] aligned_offset;
    logic [8:0]  chunk_bytes;
    logic [6:0]  length_words;
    logic [15:0] byte_enable;
    logic [1:0]  command_code;
    logic        is_bulk;
    logic        error;
    logic        last;
  } desc_t;

endpackage

[rtl/uts_chunk.sv]
// chunk size unit: picks the largest aligned chunk for the current position
`timescale 1ns / 1ps

module uts_chunk
  import uts_pkg::*;
#(
  parameter int unsigned REM_W = 9
) (
  input  logic [31:0]      off,
  input  logic [REM_W-1:0] rem,
  input  logic [3:0]       pos,
  input  logic [3:0]       mask,
  output chunk_t           ck
);

  logic [31:0] rem32;
  logic [8:0]  bulk_bytes;

  assign rem32      = 32'(rem);
  assign bulk_bytes = (rem32 >= 32'(BULK_CAP)) ? 9'(BULK_CAP) : {1'b0, rem32[7:4], 4'b0000};

  always_comb begin
    if (rem32 >= 32'd16 && off[3:0] == 4'd0 && (pos & mask) == 4'd0) begin
      ck.bytes = bulk_bytes;
      ck.words = bulk_bytes[8:2];
      ck.be    = BE_FULL;
      ck.bulk  = 1'b1;
    end else if (rem32 >= 32'd8 && off[2:0] == 3'd0) begin
      ck.bytes = 9'd8;
      ck.words = SMALL_WORDS;
      ck.be    = 16'(16'h00ff << {off[3], 3'b000});
      ck.bulk  = 1'b0;
    end else if (rem32 >= 32'd4 && off[1:0] == 2'd0) begin
      ck.bytes = 9'd4;
      ck.words = SMALL_WORDS;
      ck.be    = 16'(16'h000f << {off[3:2], 2'b00});
      ck.bulk  = 1'b0;
    end else if (rem32 >= 32'd2 && off[0] == 1'b0) begin
      ck.bytes = 9'd2;
      ck.words = SMALL_WORDS;
      ck.be    = 16'(16'h0003 << {off[3:1], 1'b0});
      ck.bulk  = 1'b0;
    end else begin
      ck.bytes = 9'd1;
      ck.words = SMALL_WORDS;
      ck.be    = 16'(16'h0001 << off[3:0]);
      ck.bulk  = 1'b0;
    end
  end

endmodule

[rtl/uts_seq.sv]
// sequencer: walks one request through the chunk unit, one descriptor per step
`timescale 1ns / 1ps

module uts_seq
  import uts_pkg::*;
#(
  parameter int unsigned REM_W = 9
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             start_err,
  input  logic [31:0]      start_off,
  input  logic [REM_W-1:0] start_rem,
  input  logic [3:0]       start_pos,
  input  logic [1:0]       start_cmd,
  input  logic [3:0]       mask,
  input  logic             out_ready,
  output logic             idle,
  output logic             out_valid,
  output desc_t            out_desc
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [31:0]      off_r, off_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [3:0]       pos_r, pos_nxt;
  logic [1:0]       cmd_r, cmd_nxt;
  logic             err_r, err_nxt;
  logic [N_W-1:0]   n_r, n_nxt;
  logic             out_valid_r, out_valid_nxt;
  desc_t            desc_r, desc_nxt;

  chunk_t           ck;
  logic             out_free;
  logic             step;
  logic [REM_W-1:0] rem_after;
  logic             last_c;

  uts_chunk #(.REM_W(REM_W)) u_chunk (
    .off  (off_r),
    .rem  (rem_r),
    .pos  (pos_r),
    .mask (mask),
    .ck   (ck)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign step      = (state_r == ST_RUN) && out_free;
  assign rem_after = rem_r - REM_W'(ck.bytes);
  assign last_c    = (rem_after == '0) || (n_r == N_W'(MAX_RESULTS - 1));

  always_comb begin
    state_nxt     = state_r;
    off_nxt       = off_r;
    rem_nxt       = rem_r;
    pos_nxt       = pos_r;
    cmd_nxt       = cmd_r;
    err_nxt       = err_r;
    n_nxt         = n_r;
    desc_nxt      = desc_r;
    out_valid_nxt = out_valid_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          off_nxt   = start_off;
          rem_nxt   = start_rem;
          pos_nxt   = start_pos;
          cmd_nxt   = start_cmd;
          err_nxt   = start_err;
          n_nxt     = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step) begin
          out_valid_nxt = 1'b1;
          if (err_r) begin
            desc_nxt       = '0;
            desc_nxt.error = 1'b1;
            desc_nxt.last  = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            desc_nxt.aligned_offset = {off_r[31:4], 4'b0000};
            desc_nxt.chunk_bytes    = ck.bytes;
            desc_nxt.length_words   = ck.words;
            desc_nxt.byte_enable    = ck.be;
            desc_nxt.command_code   = cmd_r;
            desc_nxt.is_bulk        = ck.bulk;
            desc_nxt.error          = 1'b0;
            desc_nxt.last           = last_c;
            off_nxt = off_r + 32'(ck.bytes);
            rem_nxt = rem_after;
            pos_nxt = pos_r + ck.bytes[3:0];
            n_nxt   = n_r + N_W'(1);
            if (last_c) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      err_r       <= 1'b0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      err_r       <= err_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r  <= off_nxt;
    rem_r  <= rem_nxt;
    pos_r  <= pos_nxt;
    cmd_r  <= cmd_nxt;
    desc_r <= desc_nxt;
  end

  assign idle      = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_desc  = desc_r;

endmodule

[rtl/unaligned_transfer_splitter_top.sv]
// Splits a read or write request into naturally aligned chunk descriptors, largest
// aligned chunk at each step; bulk chunks are multiples of 16 bytes up to 256 and
// need an aligned offset and a buffer position clear under buffer_align_mask. The
// input is taken while the sequencer is idle; the shared chunk unit then produces
// one descriptor per cycle while the output side takes them, so a request holds the
// input until its last descriptor is issued (at most 40 descriptors). A count above
// MAX_BYTES gives one error descriptor, and a zero count gives nothing and frees the
// input at once. The output register holds a finished descriptor until it is taken;
// the sequencer does not step on while a descriptor waits untaken.
`timescale 1ns / 1ps

module unaligned_transfer_splitter_top
  import uts_pkg::*;
#(
  parameter int unsigned MAX_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // start_offset, byte_count, buffer_low_bits, zero pad
  input  logic        in_tuser,   // operation
  // descriptor stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // aligned_offset, chunk_bytes, length_words,
                                  // byte_enable, command_code, zero pad
  output logic [1:0]  out_tuser,  // is_bulk, error
  output logic        out_tlast,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int unsigned REM_W = $clog2(MAX_BYTES + 1);

  logic [3:0]  mask_r, mask_nxt;
  logic        cfg_wr;
  logic        in_acc;
  logic [31:0] in_off;
  logic [31:0] in_count;
  logic [3:0]  in_pos;
  logic        start;
  logic        start_err;
  logic        idle;
  desc_t       desc;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign mask_nxt   = (cfg_wr && cfg_paddr[2] == 1'b0) ? cfg_pwdata[3:0] : mask_r;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {28'd0, mask_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= MASK_RESET;
    end else begin
      mask_r <= mask_nxt;
    end
  end

  // request unpacking
  assign in_off    = in_tdata[31:0];
  assign in_count  = in_tdata[63:32];
  assign in_pos    = in_tdata[67:64];
  assign in_tready = idle;
  assign in_acc    = in_tvalid && in_tready;
  assign start     = in_acc && (in_count != 32'd0);
  assign start_err = in_count > 32'(MAX_BYTES);

  uts_seq #(.REM_W(REM_W)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .start_err (start_err),
    .start_off (in_off),
    .start_rem (REM_W'(in_count)),
    .start_pos (in_pos),
    .start_cmd (in_tuser ? CMD_WRITE : CMD_READ),
    .mask      (mask_r),
    .out_ready (out_tready),
    .idle      (idle),
    .out_valid (out_tvalid),
    .out_desc  (desc)
  );

  assign out_tdata = {6'd0, desc.command_code, desc.byte_enable, desc.length_words,
                      desc.chunk_bytes, desc.aligned_offset};
  assign out_tuser = {desc.error, desc.is_bulk};
  assign out_tlast = desc.last;

  // an error descriptor always closes its request
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("error descriptor without last");

  // a nonzero request holds off the next one
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[63:32] != 32'd0 |=> !in_tready)
    else $error("request accepted while previous one in progress");

  // a chunk descriptor carries a valid command and a nonzero size
  a_chunk_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |->
      (out_tdata[65:64] == CMD_WRITE || out_tdata[65:64] == CMD_READ) &&
      out_tdata[40:32] != 9'd0)
    else $error("malformed chunk descriptor");

endmodule
